@@ sv/encoder_speed_meter_macros.svh @@
// ---------------------------------------------------------------------------
// Encoder speed meter assertion macros
// Concurrent assertion wrappers on clk and arst_n, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ENCODER_SPEED_METER_MACROS_SVH
`define ENCODER_SPEED_METER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ESM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("esm: assertion failed");
// Next-cycle implication.
`define ESM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("esm: assertion failed");
`else
`define ESM_ASSERT_IMP(lbl, ante, cons)
`define ESM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/esm_pkg.sv @@
// ---------------------------------------------------------------------------
// Encoder speed meter package
// Widths, constants, register indexes and shared types.
// ---------------------------------------------------------------------------
package esm_pkg;

	localparam int FRACTION_BITS = 4;

	localparam int PULSE_W   = 16;
	localparam int COUNT_W   = 32;
	localparam int TIME_W    = 32;
	localparam int WINDOW_W  = 16;
	localparam int CPR_W     = 12;
	localparam int SPEED_W   = 28;
	localparam int MAG_W     = 32;
	localparam int RPM_NUM_W = 16;

	localparam int NUM_W = MAG_W + RPM_NUM_W + FRACTION_BITS;
	localparam int DEN_W = TIME_W + CPR_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSED       = 2'd2;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10;
	localparam logic [CPR_W-1:0]    CPR_RESET    = 12'd44;

	localparam logic [RPM_NUM_W-1:0] RPM_NUMERATOR = 16'd60000;

	localparam logic signed [COUNT_W-1:0] FOLD_LIMIT = 32'sd32767;
	localparam logic signed [COUNT_W-1:0] FOLD_SPAN  = 32'sd65536;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_FOLD,
		ST_ABS,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

@@ sv/encoder_speed_meter.sv @@
// ---------------------------------------------------------------------------
// Encoder speed meter
// A measured poll runs through prep, fold, abs, mul, load, the 52-step
// bit-serial divider, fin and out; an unmeasured poll goes from prep to out.
// One poll at a time, taken only in idle; out waits for a free output
// register, which holds a result while the next poll is taken.
// Reset clears counts, times, held speed and travel, and loads window_ms 10,
// counts_per_rev 44 and reversed 0.
// ---------------------------------------------------------------------------
`include "encoder_speed_meter_macros.svh"

module encoder_speed_meter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// poll channel
	input  logic                                 poll_valid,
	output logic                                 poll_stall,
	input  logic signed [esm_pkg::PULSE_W-1:0]   pulse_count,
	input  logic [esm_pkg::TIME_W-1:0]           now_ms,
	input  logic                                 clear_travel,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [esm_pkg::SPEED_W-1:0]   speed_rpm_q4,
	output logic                                 speed_updated,
	output logic signed [esm_pkg::COUNT_W-1:0]   travel_counts,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [esm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [esm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import esm_pkg::*;

	// configuration
	logic [WINDOW_W-1:0] window_q;
	logic [CPR_W-1:0]    cpr_q;
	logic                reversed_q;
	logic [WINDOW_W-1:0] win_eff;
	logic [CPR_W-1:0]    cpr_eff;

	// measurement state
	state_t                     state_q, state_d;
	logic [COUNT_W-1:0]         running_q;
	logic [COUNT_W-1:0]         prev_count_q;
	logic [TIME_W-1:0]          prev_time_q;
	logic [COUNT_W-1:0]         travel_q;
	logic signed [SPEED_W-1:0]  held_speed_q;

	// per-poll working registers
	logic [TIME_W-1:0]          now_q;
	logic [TIME_W-1:0]          elapsed_q;
	logic                       meas_q;
	logic signed [COUNT_W-1:0]  diff_q;
	logic signed [COUNT_W-1:0]  delta_q;
	logic [MAG_W-1:0]           mag_q;
	logic                       neg_q;
	num_t                       num_q;
	den_t                       den_q;

	// output register
	logic                       result_valid_q;
	logic signed [SPEED_W-1:0]  speed_out_q;
	logic                       updated_out_q;
	logic [COUNT_W-1:0]         travel_out_q;

	logic               poll_xfer;
	logic               meas;
	logic               out_load;
	logic               div_start;
	logic [COUNT_W-1:0] count_ext;
	logic               over;
	num_t               div_quo;
	div_stat_t          div_stat;

	// a zero window or zero counts per revolution behaves as one
	assign win_eff = (window_q == '0) ? WINDOW_W'(1) : window_q;
	assign cpr_eff = (cpr_q == '0) ? CPR_W'(1) : cpr_q;

	assign poll_xfer = poll_valid && !poll_stall;
	assign count_ext = {{(COUNT_W-PULSE_W){pulse_count[PULSE_W-1]}}, pulse_count};
	assign meas      = elapsed_q >= TIME_W'(win_eff);

	// quotient too large for the speed field in either direction
	assign over = |div_quo[NUM_W-1:SPEED_W-1];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WINDOW_RESET;
			cpr_q      <= CPR_RESET;
			reversed_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_MS:      window_q   <= cfg_data[WINDOW_W-1:0];
				REG_COUNTS_PER_REV: cpr_q      <= cfg_data[CPR_W-1:0];
				REG_REVERSED:       reversed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake control
	always_comb begin
		state_d    = state_q;
		poll_stall = 1'b1;
		div_start  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				poll_stall = 1'b0;
				if (poll_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = meas ? ST_FOLD : ST_OUT;
			ST_FOLD: state_d = ST_ABS;
			ST_ABS:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_LOAD;
			ST_LOAD: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_OUT;
			ST_OUT: begin
				// wait for the output register to free up
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// measurement state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= '0;
			prev_count_q <= '0;
			prev_time_q  <= '0;
			travel_q     <= '0;
			held_speed_q <= '0;
		end else begin
			if (poll_xfer) begin
				// advance running count and travel, both wrap; clear_travel restarts travel
				running_q <= running_q + count_ext;
				travel_q  <= (clear_travel ? '0 : travel_q) + count_ext;
			end
			if (state_q == ST_PREP && meas) begin
				prev_count_q <= running_q;
				prev_time_q  <= now_q;
			end
			if (state_q == ST_FIN) begin
				// saturate and restore the sign
				if (neg_q) begin
					held_speed_q <= over ? SPEED_MIN
						: -$signed({1'b0, div_quo[SPEED_W-2:0]});
				end else begin
					held_speed_q <= over ? SPEED_MAX
						: $signed({1'b0, div_quo[SPEED_W-2:0]});
				end
			end
		end
	end

	// per-poll datapath, one narrow operation per step
	always_ff @(posedge clk) begin
		if (poll_xfer) begin
			now_q     <= now_ms;
			elapsed_q <= now_ms - prev_time_q;
		end
		if (state_q == ST_PREP) begin
			meas_q <= meas;
			diff_q <= $signed(running_q - prev_count_q);
		end
		if (state_q == ST_FOLD) begin
			// fold a wrapped 16-bit counter difference once
			if (diff_q > FOLD_LIMIT) begin
				delta_q <= diff_q - FOLD_SPAN;
			end else if (diff_q < -FOLD_LIMIT) begin
				delta_q <= diff_q + FOLD_SPAN;
			end else begin
				delta_q <= diff_q;
			end
			den_q <= DEN_W'(elapsed_q) * DEN_W'(cpr_eff);
		end
		if (state_q == ST_ABS) begin
			neg_q <= delta_q[COUNT_W-1];
			mag_q <= delta_q[COUNT_W-1] ? MAG_W'(-delta_q) : MAG_W'(delta_q);
		end
		if (state_q == ST_MUL) begin
			num_q <= (NUM_W'(mag_q) * NUM_W'(RPM_NUMERATOR)) << FRACTION_BITS;
		end
	end

	esm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// output register: hold until the result is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			speed_out_q   <= held_speed_q;
			updated_out_q <= meas_q;
			travel_out_q  <= reversed_q ? (COUNT_W'(0) - travel_q) : travel_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign speed_rpm_q4  = speed_out_q;
	assign speed_updated = updated_out_q;
	assign travel_counts = $signed(travel_out_q);

	`ESM_ASSERT_NXT(a_prev_time_held, !(state_q == ST_PREP && meas), $stable(prev_time_q))
	`ESM_ASSERT_IMP(a_div_quiet_idle, state_q == ST_IDLE, !div_stat.busy)

endmodule

@@ sv/esm_div.sv @@
// ---------------------------------------------------------------------------
// Encoder speed meter bit-serial divider
// Restoring division, one quotient bit per cycle through a shift register.
// ---------------------------------------------------------------------------
`include "encoder_speed_meter_macros.svh"

module esm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  esm_pkg::num_t     num,
	input  esm_pkg::den_t     den,
	output esm_pkg::num_t     quo,
	output esm_pkg::div_stat_t stat
);
	import esm_pkg::*;

	num_t             quo_q;
	den_t             rem_q;
	den_t             den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// shift in the next numerator bit, trial subtract
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`ESM_ASSERT_NXT(a_start_busy, start, busy_q)
	`ESM_ASSERT_IMP(a_rem_below_den, busy_q, rem_q < den_q)

endmodule
